@@ rtl/core/ssp_pkg.sv @@
`timescale 1ns / 1ps
// shared types, codes and constants of the servo status packet receiver
package ssp_pkg;

  localparam int NUM_IDS_DEF = 254;

  localparam logic [7:0] HDR_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_SLOT    = 2'd1,
    KIND_BYTE    = 2'd2,
    KIND_TIMEOUT = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_HUNT1 = 3'd0,
    PH_HUNT2 = 3'd1,
    PH_ID    = 3'd2,
    PH_LEN   = 3'd3,
    PH_ERR   = 3'd4,
    PH_PARAM = 3'd5,
    PH_CHK   = 3'd6
  } phase_t;

  localparam logic [2:0] ST_GOOD     = 3'd0;
  localparam logic [2:0] ST_CHK_BAD  = 3'd1;
  localparam logic [2:0] ST_LEN_BAD  = 3'd2;
  localparam logic [2:0] ST_NO_REPLY = 3'd3;
  localparam logic [2:0] ST_PARTIAL  = 3'd4;

  // one result transaction
  typedef struct packed {
    logic       write_valid;
    logic [7:0] reply_id;
    logic [7:0] table_address;
    logic [7:0] data_byte;
    logic       packet_end;
    logic [7:0] error_bits;
    logic [2:0] status_code;
    logic       all_received;
  } res_t;

  // id capture event from the parser to the start address table
  typedef struct packed {
    logic       load;
    logic [7:0] id;
  } id_evt_t;

endpackage

@@ rtl/core/ssp_item_if.sv @@
`timescale 1ns / 1ps
// input item channel of the servo status packet receiver
interface ssp_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] rx_byte;
  logic [7:0] slot_id;
  logic [7:0] slot_start;

  modport source (output valid, kind, rx_byte, slot_id, slot_start, input ready);
  modport sink (input valid, kind, rx_byte, slot_id, slot_start, output ready);
endinterface

@@ rtl/core/ssp_result_if.sv @@
`timescale 1ns / 1ps
// result channel of the servo status packet receiver
interface ssp_result_if;
  logic       valid;
  logic       ready;
  logic       write_valid;
  logic [7:0] reply_id;
  logic [7:0] table_address;
  logic [7:0] data_byte;
  logic       packet_end;
  logic [7:0] error_bits;
  logic [2:0] status_code;
  logic       all_received;

  modport source (
    output valid, write_valid, reply_id, table_address, data_byte, packet_end,
           error_bits, status_code, all_received,
    input  ready
  );
  modport sink (
    input  valid, write_valid, reply_id, table_address, data_byte, packet_end,
           error_bits, status_code, all_received,
    output ready
  );
endinterface

@@ rtl/core/ssp_start_table.sv @@
`timescale 1ns / 1ps
// per-id start address memory with valid bits and the held start of the current packet
module ssp_start_table #(
  parameter int NUM_IDS = ssp_pkg::NUM_IDS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            slot_we,
  input  logic [7:0]      slot_id,
  input  logic [7:0]      slot_start,
  input  ssp_pkg::id_evt_t id_evt,
  input  logic [7:0]      packet_id,
  output logic [7:0]      cur_start
);
  import ssp_pkg::*;

  localparam int IDX_W = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  localparam logic [7:0] ID_LIMIT = 8'(NUM_IDS);

  logic [7:0]         mem [NUM_IDS];
  logic [NUM_IDS-1:0] vld;
  logic [7:0]         rd_data;
  logic               rd_ok;
  logic               rd_pend;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (slot_we) begin
      mem[slot_id[IDX_W-1:0]] <= slot_start;
    end
    if (id_evt.load) begin
      rd_data <= mem[id_evt.id[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      rd_ok   <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      if (slot_we) begin
        vld[slot_id[IDX_W-1:0]] <= 1'b1;
      end
      rd_pend <= id_evt.load;
      if (id_evt.load) begin
        rd_ok <= (id_evt.id < ID_LIMIT) && vld[id_evt.id[IDX_W-1:0]];
      end
    end
  end

  // a slot load to the current id overrides the memory copy
  always_ff @(posedge clk) begin
    if (slot_we && (slot_id == packet_id)) begin
      cur_start <= slot_start;
    end else if (rd_pend) begin
      cur_start <= rd_ok ? rd_data : 8'd0;
    end
  end

endmodule

@@ rtl/core/ssp_parser.sv @@
`timescale 1ns / 1ps
// packet phase tracking, checksum and result formation for one accepted transaction per cycle
module ssp_parser #(
  parameter int NUM_IDS = ssp_pkg::NUM_IDS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [1:0]       kind,
  input  logic [7:0]       rx_byte,
  input  logic [7:0]       slot_id,
  input  logic [7:0]       cur_start,
  output logic             slot_we,
  output ssp_pkg::id_evt_t id_evt,
  output logic [7:0]       packet_id,
  output logic             res_valid,
  output ssp_pkg::res_t    res
);
  import ssp_pkg::*;

  localparam logic [7:0] ID_LIMIT = 8'(NUM_IDS);

  phase_t     phase, phase_next;
  logic [7:0] packet_id_next;
  logic [7:0] packet_length, packet_length_next;
  logic [7:0] packet_error, packet_error_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] param_offset, param_offset_next;
  logic [7:0] replies, replies_next;
  logic       byte_seen, byte_seen_next;
  logic [7:0] offset_inc;
  logic [7:0] param_count;

  assign offset_inc  = param_offset + 8'd1;
  assign param_count = packet_length - 8'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT1;
      packet_id     <= 8'd0;
      packet_length <= 8'd0;
      packet_error  <= 8'd0;
      running_sum   <= 8'd0;
      param_offset  <= 8'd0;
      replies       <= 8'd0;
      byte_seen     <= 1'b0;
    end else begin
      phase         <= phase_next;
      packet_id     <= packet_id_next;
      packet_length <= packet_length_next;
      packet_error  <= packet_error_next;
      running_sum   <= running_sum_next;
      param_offset  <= param_offset_next;
      replies       <= replies_next;
      byte_seen     <= byte_seen_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    packet_id_next     = packet_id;
    packet_length_next = packet_length;
    packet_error_next  = packet_error;
    running_sum_next   = running_sum;
    param_offset_next  = param_offset;
    replies_next       = replies;
    byte_seen_next     = byte_seen;
    slot_we            = 1'b0;
    id_evt             = '0;
    res_valid          = 1'b0;
    res                = '0;
    if (accept) begin
      case (kind_t'(kind))
        KIND_CLEAR: begin
          replies_next   = 8'd0;
          byte_seen_next = 1'b0;
          phase_next     = PH_HUNT1;
        end
        KIND_SLOT: begin
          if (slot_id < ID_LIMIT) begin
            slot_we = 1'b1;
            if (replies != 8'hFF) begin
              replies_next = replies + 8'd1;
            end
          end
        end
        KIND_TIMEOUT: begin
          byte_seen_next  = 1'b0;
          phase_next      = PH_HUNT1;
          res_valid       = 1'b1;
          res.packet_end  = 1'b1;
          res.status_code = byte_seen ? ST_PARTIAL : ST_NO_REPLY;
        end
        KIND_BYTE: begin
          byte_seen_next = 1'b1;
          case (phase)
            PH_HUNT1: begin
              if (rx_byte == HDR_BYTE) begin
                phase_next = PH_HUNT2;
              end
            end
            PH_HUNT2: begin
              phase_next = (rx_byte == HDR_BYTE) ? PH_ID : PH_HUNT1;
            end
            PH_ID: begin
              // extra header bytes are skipped
              if (rx_byte != HDR_BYTE) begin
                packet_id_next   = rx_byte;
                running_sum_next = rx_byte;
                phase_next       = PH_LEN;
                id_evt.load      = 1'b1;
                id_evt.id        = rx_byte;
              end
            end
            PH_LEN: begin
              packet_length_next = rx_byte;
              running_sum_next   = running_sum + rx_byte;
              if (rx_byte < 8'd2) begin
                phase_next      = PH_HUNT1;
                res_valid       = 1'b1;
                res.reply_id    = packet_id;
                res.packet_end  = 1'b1;
                res.status_code = ST_LEN_BAD;
              end else begin
                phase_next = PH_ERR;
              end
            end
            PH_ERR: begin
              packet_error_next = rx_byte;
              running_sum_next  = running_sum + rx_byte;
              param_offset_next = 8'd0;
              phase_next        = (packet_length == 8'd2) ? PH_CHK : PH_PARAM;
            end
            PH_PARAM: begin
              running_sum_next  = running_sum + rx_byte;
              param_offset_next = offset_inc;
              if (offset_inc >= param_count) begin
                phase_next = PH_CHK;
              end
              res_valid         = 1'b1;
              res.write_valid   = 1'b1;
              res.reply_id      = packet_id;
              res.table_address = cur_start + param_offset;
              res.data_byte     = rx_byte;
            end
            PH_CHK: begin
              phase_next = PH_HUNT1;
              if (rx_byte == ~running_sum) begin
                res.status_code = ST_GOOD;
                if (replies != 8'd0) begin
                  replies_next = replies - 8'd1;
                end
              end else begin
                res.status_code = ST_CHK_BAD;
              end
              res_valid      = 1'b1;
              res.reply_id   = packet_id;
              res.packet_end = 1'b1;
              res.error_bits = packet_error;
            end
            default: begin
              phase_next = PH_HUNT1;
            end
          endcase
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
    res.all_received = (replies_next == 8'd0);
  end

endmodule

@@ rtl/core/ssp_out_buf.sv @@
`timescale 1ns / 1ps
// output register with a skid stage
module ssp_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ssp_pkg::res_t push_data,
  output logic          can_push,
  ssp_result_if.source  result
);
  import ssp_pkg::*;

  logic out_valid;
  res_t out_data;
  logic skid_valid;
  res_t skid_data;

  assign can_push = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !result.ready) begin
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !result.ready) begin
      if (push) begin
        skid_data <= push_data;
      end
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else if (push) begin
      out_data <= push_data;
    end
  end

  assign result.valid         = out_valid;
  assign result.write_valid   = out_data.write_valid;
  assign result.reply_id      = out_data.reply_id;
  assign result.table_address = out_data.table_address;
  assign result.data_byte     = out_data.data_byte;
  assign result.packet_end    = out_data.packet_end;
  assign result.error_bits    = out_data.error_bits;
  assign result.status_code   = out_data.status_code;
  assign result.all_received  = out_data.all_received;

endmodule

@@ rtl/core/servo_status_packet_receiver_core.sv @@
`timescale 1ns / 1ps
// top level of the servo status packet receiver
//
// item channel: one transaction per cycle while item.ready is high, each with a kind code plus its payload;
//   clear request slots, load a bulk-read slot (id and table start address),
//   one received bus byte, or a reply timeout
// result channel: at most one transaction per item; either a parameter byte
//   table write (write_valid) or a packet end / timeout report (packet_end)
//   with error bits, status code and the all_received flag
// throughput: one item per cycle while item.ready is high; the
//   running checksum adds one byte per cycle
// result path: each result is registered, in the output register or first in the skid entry
// start address memory: read once when the id byte arrives, the data is
//   held in a register well before the first parameter byte needs it
// reset: parser hunts for the first header byte, counters and all start
//   addresses read as zero (valid bits cleared, no clearing pass)
// stall: an output register plus one skid entry; items keep flowing while
//   one result waits, item.ready drops only when both entries hold results
module servo_status_packet_receiver_core #(
  parameter int NUM_IDS = ssp_pkg::NUM_IDS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  ssp_item_if.sink     item,
  ssp_result_if.source result
);
  import ssp_pkg::*;

  logic       accept;
  logic       can_push;
  logic       slot_we;
  id_evt_t    id_evt;
  logic [7:0] packet_id;
  logic [7:0] cur_start;
  logic       res_valid;
  res_t       res;

  // new items are taken while the skid entry is free
  assign item.ready = can_push;
  assign accept     = item.valid && can_push;

  ssp_parser #(
    .NUM_IDS (NUM_IDS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .kind      (item.kind),
    .rx_byte   (item.rx_byte),
    .slot_id   (item.slot_id),
    .cur_start (cur_start),
    .slot_we   (slot_we),
    .id_evt    (id_evt),
    .packet_id (packet_id),
    .res_valid (res_valid),
    .res       (res)
  );

  // per-id start addresses for parameter table writes
  ssp_start_table #(
    .NUM_IDS (NUM_IDS)
  ) u_start_table (
    .clk        (clk),
    .rst        (rst),
    .slot_we    (slot_we),
    .slot_id    (item.slot_id),
    .slot_start (item.slot_start),
    .id_evt     (id_evt),
    .packet_id  (packet_id),
    .cur_start  (cur_start)
  );

  // result register and skid entry
  ssp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .can_push  (can_push),
    .result    (result)
  );

  // skid entry only fills while the output register is stalled
  a_ready_low_only_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> result.valid)
    else $error("item channel blocked with empty output register");

  // a timeout into a free output always reports the next cycle
  a_timeout_reports: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && item.kind == KIND_TIMEOUT && !result.valid)
      |=> (result.valid && result.packet_end && !result.write_valid))
    else $error("timeout transaction gave no end report");

  // table writes carry no end status
  a_write_clean: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.write_valid)
      |-> (!result.packet_end && result.status_code == ST_GOOD))
    else $error("table write transaction carries end status");

endmodule

@@ test/servo_status_packet_receiver_core_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the servo status packet receiver: packet, slot and timeout traffic
module servo_status_packet_receiver_core_tb;
  import ssp_pkg::*;

  localparam int NUM_IDS      = NUM_IDS_DEF;
  localparam int ITEM_TARGET  = 1200;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int LIMIT_CYCLES = 400000;

  // tracks the parser state seen from outside and predicts each result transaction
  class reply_tracker;
    phase_t     phase;
    logic [7:0] pkt_id;
    logic [7:0] pkt_len;
    logic [7:0] pkt_err;
    logic [7:0] sum;
    logic [7:0] offset;
    logic [7:0] replies_left;
    bit         got_byte;
    logic [7:0] slot_base [NUM_IDS];
    res_t       expected_results [$];
    int         mismatches;

    function new();
      phase        = PH_HUNT1;
      pkt_id       = '0;
      pkt_len      = '0;
      pkt_err      = '0;
      sum          = '0;
      offset       = '0;
      replies_left = '0;
      got_byte     = 1'b0;
      foreach (slot_base[i]) slot_base[i] = '0;
      mismatches   = 0;
    endfunction

    function void push_result(res_t r);
      r.all_received = (replies_left == 8'd0);
      expected_results.push_back(r);
    endfunction

    function void take_item(kind_t k, logic [7:0] b, logic [7:0] sid, logic [7:0] sst);
      res_t       r;
      logic [7:0] addr;
      r = '0;
      case (k)
        KIND_CLEAR: begin
          replies_left = 8'd0;
          got_byte     = 1'b0;
          phase        = PH_HUNT1;
        end
        KIND_SLOT: begin
          if (sid < NUM_IDS) begin
            slot_base[sid] = sst;
            if (replies_left != 8'hFF) replies_left++;
          end
        end
        KIND_TIMEOUT: begin
          r.packet_end  = 1'b1;
          r.status_code = got_byte ? ST_PARTIAL : ST_NO_REPLY;
          got_byte      = 1'b0;
          phase         = PH_HUNT1;
          push_result(r);
        end
        default: begin
          got_byte = 1'b1;
          case (phase)
            PH_HUNT1: if (b == HDR_BYTE) phase = PH_HUNT2;
            PH_HUNT2: phase = (b == HDR_BYTE) ? PH_ID : PH_HUNT1;
            PH_ID: begin
              if (b != HDR_BYTE) begin
                pkt_id = b;
                sum    = b;
                phase  = PH_LEN;
              end
            end
            PH_LEN: begin
              pkt_len = b;
              sum     = sum + b;
              if (b < 8'd2) begin
                phase         = PH_HUNT1;
                r.reply_id    = pkt_id;
                r.packet_end  = 1'b1;
                r.status_code = ST_LEN_BAD;
                push_result(r);
              end else begin
                phase = PH_ERR;
              end
            end
            PH_ERR: begin
              pkt_err = b;
              sum     = sum + b;
              offset  = 8'd0;
              phase   = (pkt_len == 8'd2) ? PH_CHK : PH_PARAM;
            end
            PH_PARAM: begin
              addr   = ((pkt_id < NUM_IDS) ? slot_base[pkt_id] : 8'd0) + offset;
              sum    = sum + b;
              offset = offset + 8'd1;
              if (offset >= pkt_len - 8'd2) phase = PH_CHK;
              r.write_valid   = 1'b1;
              r.reply_id      = pkt_id;
              r.table_address = addr;
              r.data_byte     = b;
              push_result(r);
            end
            PH_CHK: begin
              phase = PH_HUNT1;
              if (b == ~sum) begin
                r.status_code = ST_GOOD;
                if (replies_left != 8'd0) replies_left--;
              end else begin
                r.status_code = ST_CHK_BAD;
              end
              r.reply_id   = pkt_id;
              r.packet_end = 1'b1;
              r.error_bits = pkt_err;
              push_result(r);
            end
            default: phase = PH_HUNT1;
          endcase
        end
      endcase
    endfunction

    function string show(res_t r);
      return $sformatf("wv=%0d id=%h addr=%h data=%h end=%0d err=%h st=%0d all=%0d",
                       r.write_valid, r.reply_id, r.table_address, r.data_byte,
                       r.packet_end, r.error_bits, r.status_code, r.all_received);
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, what);
    endfunction

    function void check_result(res_t got);
      res_t  want;
      string bad;
      if (expected_results.size() == 0) begin
        flag({"unexpected result: ", show(got)});
        return;
      end
      want = expected_results.pop_front();
      bad  = "";
      if (got.write_valid !== want.write_valid)     bad = {bad, " write_valid"};
      if (got.reply_id !== want.reply_id)           bad = {bad, " reply_id"};
      if (got.table_address !== want.table_address) bad = {bad, " table_address"};
      if (got.data_byte !== want.data_byte)         bad = {bad, " data_byte"};
      if (got.packet_end !== want.packet_end)       bad = {bad, " packet_end"};
      if (got.error_bits !== want.error_bits)       bad = {bad, " error_bits"};
      if (got.status_code !== want.status_code)     bad = {bad, " status_code"};
      if (got.all_received !== want.all_received)   bad = {bad, " all_received"};
      if (bad != "") flag({"mismatch in", bad, ": expected ", show(want), ", got ", show(got)});
    endfunction
  endclass

  logic clk;
  logic rst;

  ssp_item_if   item_ch ();
  ssp_result_if result_ch ();

  servo_status_packet_receiver_core u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  reply_tracker tracker;

  // idle percentages per side, changed as the run moves through its phases
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int items_sent  = 0;
  int cycle_count = 0;

  // long receiver hold-off, armed once by the stimulus and counted here
  bit hold_armed = 1'b0;
  bit hold_used  = 1'b0;
  int hold_left  = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver side: random stalls, plus one long stretch that backs up the block
  always @(posedge clk) begin
    if (hold_armed && !hold_used) begin
      hold_left = HOLD_CYCLES;
      hold_used = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // one monitor for both channels so results are checked before the same edge's item is noted
  always @(posedge clk) begin : watch
    res_t got;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        got.write_valid   = result_ch.write_valid;
        got.reply_id      = result_ch.reply_id;
        got.table_address = result_ch.table_address;
        got.data_byte     = result_ch.data_byte;
        got.packet_end    = result_ch.packet_end;
        got.error_bits    = result_ch.error_bits;
        got.status_code   = result_ch.status_code;
        got.all_received  = result_ch.all_received;
        tracker.check_result(got);
      end
      if (item_ch.valid && item_ch.ready)
        tracker.take_item(kind_t'(item_ch.kind), item_ch.rx_byte, item_ch.slot_id,
                          item_ch.slot_start);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("servo_status_packet_receiver_core_tb: FAIL");
      $finish;
    end
  end

  // offer one item and hold it until the block takes it; valid stays up for the next call
  task automatic send_item(input kind_t k, input logic [7:0] b, input logic [7:0] sid,
                           input logic [7:0] sst);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.kind       <= k;
    item_ch.rx_byte    <= b;
    item_ch.slot_id    <= sid;
    item_ch.slot_start <= sst;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    // loads of out-of-range slots are dropped by the block
    if (!(k == KIND_SLOT && sid >= NUM_IDS)) items_sent++;
  endtask

  // header, optional extra 0xff bytes, id, length, and for a length of at least 2 error, params, checksum;
  // cut >= 0 stops after that many bytes
  task automatic send_packet(input logic [7:0] id, input logic [7:0] len,
                             input logic [7:0] err, input bit bad_sum, input int extra_hdr,
                             input int cut);
    logic [7:0] frame [$];
    logic [7:0] sum;
    logic [7:0] p;
    frame = {HDR_BYTE, HDR_BYTE};
    repeat (extra_hdr) frame.push_back(HDR_BYTE);
    frame.push_back(id);
    frame.push_back(len);
    sum = id + len;
    if (len >= 8'd2) begin
      frame.push_back(err);
      sum = sum + err;
      repeat (len - 8'd2) begin
        p = 8'($urandom);
        frame.push_back(p);
        sum = sum + p;
      end
      // a corrupt checksum flips at least one bit
      frame.push_back(bad_sum ? ((~sum) ^ 8'($urandom_range(255, 1))) : ~sum);
    end
    foreach (frame[i])
      if (cut < 0 || i < cut) send_item(KIND_BYTE, frame[i], 8'($urandom), 8'($urandom));
  endtask

  initial begin
    int         roll;
    int         sub;
    bit         burst_done;
    logic [7:0] id;
    logic [7:0] len;

    burst_done         = 1'b0;
    tracker            = new();
    rst                <= 1'b1;
    item_ch.valid      <= 1'b0;
    item_ch.kind       <= KIND_CLEAR;
    item_ch.rx_byte    <= 8'd0;
    item_ch.slot_id    <= 8'd0;
    item_ch.slot_start <= 8'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: timeout with nothing received
    send_item(KIND_TIMEOUT, 8'h00, 8'h00, 8'h00);
    // slot load near the top of the table so parameter addresses wrap
    send_item(KIND_SLOT, 8'hFF, 8'd5, 8'hFF);
    // slot ids past the table are dropped
    send_item(KIND_SLOT, 8'h00, 8'd254, 8'h00);
    send_item(KIND_SLOT, 8'h00, 8'hFF, 8'hAA);
    // good packet with two params: addresses 0xff then 0x00
    send_packet(8'd5, 8'd4, 8'h80, 1'b0, 0, -1);
    // broken header
    send_item(KIND_BYTE, HDR_BYTE, 8'h00, 8'h00);
    send_item(KIND_BYTE, 8'h00, 8'h00, 8'h00);
    // extra header byte, unknown id, no params, corrupt checksum
    send_packet(8'd254, 8'd2, 8'h7F, 1'b1, 1, -1);
    // short length
    send_packet(8'd3, 8'd1, 8'h00, 1'b0, 0, -1);
    // bytes since the last timeout, so this one reports a partial reply
    send_item(KIND_TIMEOUT, 8'hFF, 8'hFF, 8'hFF);
    send_item(KIND_CLEAR, 8'h5A, 8'hA5, 8'h3C);

    // random part, with the long receiver hold-off right at its start
    hold_armed = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent < ITEM_TARGET / 3) begin
        tx_idle_pct = 22;
        rx_idle_pct = 47;
      end else if (items_sent < 2 * ITEM_TARGET / 3) begin
        tx_idle_pct = 47;
        rx_idle_pct = 22;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      // once, enough slot loads in a row to saturate the reply count
      if (!burst_done && items_sent > ITEM_TARGET / 2) begin
        repeat (260)
          send_item(KIND_SLOT, 8'($urandom), 8'($urandom_range(NUM_IDS - 1)), 8'($urandom));
        burst_done = 1'b1;
      end

      // mostly known ids, now and then any legal id including unknown ones
      id  = ($urandom_range(9) == 0) ? 8'($urandom_range(254)) : 8'($urandom_range(15));
      sub = $urandom_range(99);
      if (sub < 6)       len = 8'($urandom_range(1));
      else if (sub < 76) len = 8'($urandom_range(6, 2));
      else if (sub < 94) len = 8'($urandom_range(20, 7));
      else               len = 8'($urandom_range(255, 21));

      roll = $urandom_range(99);
      if (roll < 55) begin
        send_packet(id, len, 8'($urandom), $urandom_range(99) < 15,
                    ($urandom_range(99) < 10) ? $urandom_range(3, 1) : 0, -1);
      end else if (roll < 65) begin
        // truncated packet, often followed by a timeout
        send_packet(id, len, 8'($urandom), 1'b0, 0, $urandom_range(8, 1));
        if ($urandom_range(1) == 1) send_item(KIND_TIMEOUT, 8'($urandom), 8'($urandom),
                                              8'($urandom));
      end else if (roll < 77) begin
        send_item(KIND_SLOT, 8'($urandom),
                  ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(15)),
                  8'($urandom));
      end else if (roll < 85) begin
        // line noise, biased toward header bytes
        repeat ($urandom_range(4, 1))
          send_item(KIND_BYTE, ($urandom_range(3) == 0) ? HDR_BYTE : 8'($urandom),
                    8'($urandom), 8'($urandom));
      end else if (roll < 95) begin
        send_item(KIND_TIMEOUT, 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        send_item(KIND_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end

    // all items taken; let every result come out, then give the block time to misbehave
    item_ch.valid <= 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0) begin
      $display("servo_status_packet_receiver_core_tb: PASS");
    end else begin
      $display("servo_status_packet_receiver_core_tb: FAIL");
    end
    $finish;
  end

endmodule
